### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int PRIORITY_BITS = 16;
  localparam int VALUE_BITS    = 32;
  localparam int COUNT_W       = $clog2(CAPACITY + 1);

  // Command codes carried in s_tuser.
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  typedef struct packed {
    logic [VALUE_BITS-1:0]    value;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  // Operation broadcast to every cell in the row.
  typedef struct packed {
    logic enq;
    logic deq;
  } spq_op_t;

endpackage

### rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds an entry and shifts towards either
// neighbour on an insert or a removal.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic            clk,
  input  spq_pkg::spq_op_t op,
  input  spq_pkg::entry_t new_entry,
  input  spq_pkg::entry_t left_entry,
  input  spq_pkg::entry_t right_entry,
  input  logic            left_le,
  input  logic            occupied,
  output logic            le,
  output spq_pkg::entry_t entry
);
  import spq_pkg::*;

  // The new entry goes after every held entry with a priority not greater.
  assign le = occupied && (entry.prio <= new_entry.prio);

  always_ff @(posedge clk) begin
    if (op.enq && !le) begin
      // The first cell that does not stay takes the new entry; the ones
      // behind it take their left neighbour's entry.
      entry <= left_le ? new_entry : left_entry;
    end else if (op.deq) begin
      entry <= right_entry;
    end
  end

endmodule

### rtl/sorted_priority_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Sorted priority queue built as a row of cells; ties leave in arrival order.
// ----------------------------------------------------------------------------
// Result: the result of a request is registered and is on the master side in
// the cycle after the request is taken.
// Throughput: one request per cycle, as the whole cell row updates at once;
// s_tready falls only while a result waits on m_tready.
// Reset: rst clears the fill count and the result valid flag; entry storage
// and the result payload are not cleared.
module sorted_priority_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // item_value[31:0], item_priority[47:32]
  input  logic [0:0]  s_tuser,   // command[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_value[31:0], out_priority[47:32],
                                 // fill_count[52:48], zero fill[55:53]
  output logic [2:0]  m_tuser    // out_valid[0], underflow[1], overflow[2]
);
  import spq_pkg::*;

  logic                accept;
  logic                full;
  logic                empty;
  logic                is_deq;
  spq_op_t             op;
  entry_t              new_entry;
  entry_t              cell_entry [CAPACITY];
  logic                cell_le    [CAPACITY];
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  count_next;
  logic [VALUE_BITS-1:0]    res_value;
  logic [PRIORITY_BITS-1:0] res_prio;
  logic [COUNT_W-1:0]  res_fill;
  logic                res_valid;
  logic                res_under;
  logic                res_over;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign is_deq    = (s_tuser[0] == CMD_DEQUEUE);
  assign full      = (count == COUNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign new_entry = '{value: s_tdata[31:0], prio: s_tdata[47:32]};

  always_comb begin
    op.enq     = accept && !is_deq && !full;
    op.deq     = accept && is_deq && !empty;
    count_next = count;
    if (op.enq) begin
      count_next = count + COUNT_W'(1);
    end else if (op.deq) begin
      count_next = count - COUNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_l;

    if (i == 0) begin : g_first
      assign left_e = new_entry;
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_l = cell_le[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .op         (op),
      .new_entry  (new_entry),
      .left_entry (left_e),
      .right_entry(right_e),
      .left_le    (left_l),
      .occupied   (COUNT_W'(i) < count),
      .le         (cell_le[i]),
      .entry      (cell_entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload; the front cell supplies a removed entry.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_value <= op.deq ? cell_entry[0].value : '0;
      res_prio  <= op.deq ? cell_entry[0].prio  : '0;
      res_valid <= op.deq;
      res_under <= is_deq && empty;
      res_over  <= !is_deq && full;
      res_fill  <= count_next;
    end
  end

  assign m_tdata[31:0]  = res_value;
  assign m_tdata[47:32] = res_prio;
  assign m_tdata[52:48] = res_fill;
  assign m_tdata[55:53] = 3'b000;
  assign m_tuser        = {res_over, res_under, res_valid};

endmodule

### rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [2:0]  m_tuser
);
  import spq_pkg::*;

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // At most one of out_valid, underflow and overflow is set.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(m_tuser) <= 1)
    else $error("conflicting result flags");

  // Without a removed entry the value and priority read as zero.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[47:0] == '0)
    else $error("non-zero payload without an entry");

  // A refused insert only happens with the row full.
  a_over: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tdata[52:48] == 5'(CAPACITY))
    else $error("overflow below capacity");

  // The fill count never exceeds capacity.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[52:48] <= 5'(CAPACITY))
    else $error("fill count above capacity");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

### tb/sorted_priority_queue_top_tb.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_top_tb
// Self-checking bench for the sorted priority queue. Enqueue and dequeue
// requests go in on the slave stream. A scoreboard keeps its own sorted copy
// of the queue and predicts each result. Results on the master stream are
// checked field by field, in order, under random gaps, random back-pressure
// and one long output stall.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  typedef struct {
    logic [VALUE_BITS-1:0]    value;
    logic [PRIORITY_BITS-1:0] prio;
    logic [COUNT_W-1:0]       fill;
    logic                     valid;
    logic                     under;
    logic                     over;
  } queue_result_t;

  class priority_queue_scoreboard;
    logic [VALUE_BITS-1:0]    held_value [CAPACITY];
    logic [PRIORITY_BITS-1:0] held_prio  [CAPACITY];
    int                       held_count = 0;
    queue_result_t            expected_results [$];
    int errors = 0;
    int n_enq = 0;
    int n_deq = 0;
    int n_under = 0;
    int n_over = 0;
    int peak_fill = 0;

    // Works out the result of one accepted request and updates the held queue.
    function void note_request(logic cmd, logic [VALUE_BITS-1:0] value,
                               logic [PRIORITY_BITS-1:0] prio);
      queue_result_t r;
      int pos;
      int i;
      r = '{default: '0};
      if (cmd == CMD_ENQUEUE) begin
        n_enq++;
        if (held_count >= CAPACITY) begin
          r.over = 1'b1;
          n_over++;
        end else begin
          // A new entry goes behind every entry of equal or smaller priority.
          pos = 0;
          while (pos < held_count && held_prio[pos] <= prio) pos++;
          for (i = held_count; i > pos; i--) begin
            held_value[i] = held_value[i-1];
            held_prio[i]  = held_prio[i-1];
          end
          held_value[pos] = value;
          held_prio[pos]  = prio;
          held_count++;
        end
      end else begin
        n_deq++;
        if (held_count == 0) begin
          r.under = 1'b1;
          n_under++;
        end else begin
          r.value = held_value[0];
          r.prio  = held_prio[0];
          r.valid = 1'b1;
          for (i = 0; i < held_count - 1; i++) begin
            held_value[i] = held_value[i+1];
            held_prio[i]  = held_prio[i+1];
          end
          held_count--;
        end
      end
      r.fill = held_count[COUNT_W-1:0];
      if (held_count > peak_fill) peak_fill = held_count;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [55:0] tdata, logic [2:0] tuser);
      queue_result_t want;
      if (expected_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("out_value",    64'(want.value), 64'(tdata[31:0]));
      compare_field("out_priority", 64'(want.prio),  64'(tdata[47:32]));
      compare_field("fill_count",   64'(want.fill),  64'(tdata[52:48]));
      compare_field("out_valid",    64'(want.valid), 64'(tuser[0]));
      compare_field("underflow",    64'(want.under), 64'(tuser[1]));
      compare_field("overflow",     64'(want.over),  64'(tuser[2]));
    endfunction
  endclass

  localparam logic [15:0] FILL_PRIO [16] = '{
    16'h0000, 16'hFFFF, 16'h0005, 16'h0005, 16'h0005, 16'h0000, 16'hFFFF, 16'h0001,
    16'h8000, 16'h7FFF, 16'h0005, 16'h0000, 16'hFFFF, 16'h0002, 16'h0005, 16'h0003
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;

  // Shared between the sender and the receiver.
  bit steady     = 1'b0;
  bit hold_start = 1'b0;

  priority_queue_scoreboard sb = new();

  sorted_priority_queue_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (s_tvalid && s_tready) sb.note_request(s_tuser[0], s_tdata[31:0], s_tdata[47:32]);
    end
  end

  // Entered just after a falling edge; returns just after the falling edge
  // that follows acceptance of the request.
  task automatic send_request(input logic cmd, input logic [31:0] value,
                              input logic [15:0] prio);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 26) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {prio, value};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int enq_pct);
    logic [15:0] prio;
    case ($urandom_range(3))
      0: prio = 16'($urandom_range(3));
      1: prio = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: prio = 16'($urandom_range(65535));
    endcase
    send_request(($urandom_range(99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE,
                 $urandom, prio);
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = 80;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 26);
      end
    end
  end

  initial begin
    int n;
    int enq_pct;
    int waited;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_ENQUEUE;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: underflow on an empty queue, fill with extremes and ties,
    // overflow when full, then a few dequeues with junk in the ignored fields.
    send_request(CMD_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
    for (n = 0; n < CAPACITY; n++) begin
      case (n)
        0: send_request(CMD_ENQUEUE, 32'h7FFF_FFFF, FILL_PRIO[n]);
        1: send_request(CMD_ENQUEUE, 32'h8000_0000, FILL_PRIO[n]);
        2: send_request(CMD_ENQUEUE, 32'h0000_0000, FILL_PRIO[n]);
        3: send_request(CMD_ENQUEUE, 32'hFFFF_FFFF, FILL_PRIO[n]);
        default: send_request(CMD_ENQUEUE, $urandom, FILL_PRIO[n]);
      endcase
    end
    send_request(CMD_ENQUEUE, 32'h1234_5678, 16'h0000);
    send_request(CMD_DEQUEUE, 32'h0000_0000, 16'h0000);
    send_request(CMD_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(CMD_DEQUEUE, 32'h5555_AAAA, 16'hA5A5);

    // Random: phases sweep the fill level between empty and full.
    for (n = 0; n < 1200; n++) begin
      case ((n / 100) % 4)
        0: enq_pct = 75;
        1: enq_pct = 20;
        2: enq_pct = 50;
        default: enq_pct = 90;
      endcase
      steady = (n >= 400 && n < 550);
      if (n == 700) hold_start = 1'b1;
      send_random(enq_pct);
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    waited = 0;
    while (sb.expected_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      $error("%0d results never arrived", sb.expected_results.size());
      sb.errors++;
    end

    $display("Ran %0d enqueues (%0d refused when full) and %0d dequeues (%0d on empty).",
             sb.n_enq, sb.n_over, sb.n_deq, sb.n_under);
    $display("Queue filled to %0d of %0d entries, with one long output stall.",
             sb.peak_fill, CAPACITY);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
